@@ rtl/lkdr_pkg.sv @@
package lkdr_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int TIME_BITS   = 32;
  localparam int CFG_BITS    = 24;
  localparam int COUNT_BITS  = 4;
  localparam int KEY_BITS    = 3;
  localparam int ADDR_BITS   = 4;
  localparam int DATA_BITS   = 32;

  // compare widths wide enough for both operands
  localparam int CMP_BITS  = (SAMPLE_BITS > 10) ? SAMPLE_BITS : 10;
  localparam int DIFF_BITS = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // band edges of the ladder voltage
  localparam logic [CMP_BITS-1:0] EDGE_900 = CMP_BITS'(900);
  localparam logic [CMP_BITS-1:0] EDGE_700 = CMP_BITS'(700);
  localparam logic [CMP_BITS-1:0] EDGE_600 = CMP_BITS'(600);
  localparam logic [CMP_BITS-1:0] EDGE_400 = CMP_BITS'(400);
  localparam logic [CMP_BITS-1:0] EDGE_300 = CMP_BITS'(300);
  localparam logic [CMP_BITS-1:0] EDGE_100 = CMP_BITS'(100);

  localparam logic [KEY_BITS-1:0] KEY_NONE = 3'd0;
  localparam logic [KEY_BITS-1:0] KEY_1    = 3'd1;
  localparam logic [KEY_BITS-1:0] KEY_2    = 3'd2;
  localparam logic [KEY_BITS-1:0] KEY_3    = 3'd3;
  localparam logic [KEY_BITS-1:0] KEY_4    = 3'd4;
  localparam logic [KEY_BITS-1:0] KEY_5    = 3'd5;
  localparam logic [KEY_BITS-1:0] KEY_6    = 3'd6;

  typedef enum logic [1:0] {
    REG_SLOW_DELAY = 2'd0,
    REG_FAST_DELAY = 2'd1,
    REG_IDLE_TIME  = 2'd2,
    REG_FAST_AFTER = 2'd3
  } reg_idx_e;

  localparam logic [CFG_BITS-1:0]   SLOW_DELAY_RST = CFG_BITS'(200000);
  localparam logic [CFG_BITS-1:0]   FAST_DELAY_RST = CFG_BITS'(80000);
  localparam logic [CFG_BITS-1:0]   IDLE_TIME_RST  = CFG_BITS'(400000);
  localparam logic [COUNT_BITS-1:0] FAST_AFTER_RST = COUNT_BITS'(5);

  typedef struct packed {
    logic [CFG_BITS-1:0]   slow_repeat_delay;
    logic [CFG_BITS-1:0]   fast_repeat_delay;
    logic [CFG_BITS-1:0]   idle_reset_time;
    logic [COUNT_BITS-1:0] fast_after_count;
  } cfg_t;

endpackage

@@ rtl/lkdr_cfg.sv @@
module lkdr_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lkdr_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [lkdr_pkg::DATA_BITS-1:0]   pwdata,
  output logic [lkdr_pkg::DATA_BITS-1:0]   prdata,
  output logic                             pready,
  output lkdr_pkg::cfg_t                   cfg_o
);
  import lkdr_pkg::*;

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_e'(paddr[ADDR_BITS-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slow_repeat_delay <= SLOW_DELAY_RST;
      cfg_q.fast_repeat_delay <= FAST_DELAY_RST;
      cfg_q.idle_reset_time   <= IDLE_TIME_RST;
      cfg_q.fast_after_count  <= FAST_AFTER_RST;
    end else if (wr_en) begin
      case (idx)
        REG_SLOW_DELAY: cfg_q.slow_repeat_delay <= pwdata[CFG_BITS-1:0];
        REG_FAST_DELAY: cfg_q.fast_repeat_delay <= pwdata[CFG_BITS-1:0];
        REG_IDLE_TIME:  cfg_q.idle_reset_time   <= pwdata[CFG_BITS-1:0];
        REG_FAST_AFTER: cfg_q.fast_after_count  <= pwdata[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SLOW_DELAY: prdata = DATA_BITS'(cfg_q.slow_repeat_delay);
      REG_FAST_DELAY: prdata = DATA_BITS'(cfg_q.fast_repeat_delay);
      REG_IDLE_TIME:  prdata = DATA_BITS'(cfg_q.idle_reset_time);
      REG_FAST_AFTER: prdata = DATA_BITS'(cfg_q.fast_after_count);
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/lkdr_classify.sv @@
module lkdr_classify (
  input  logic [lkdr_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic [lkdr_pkg::KEY_BITS-1:0]    code_o
);
  import lkdr_pkg::*;

  logic [CMP_BITS-1:0] v;

  assign v = CMP_BITS'(sample_i);

  // values exactly on an edge fall through to no key
  always_comb begin
    case (v) inside
      [EDGE_700 + 1'b1 : EDGE_900 - 1'b1]: code_o = KEY_1;
      [EDGE_600 + 1'b1 : EDGE_700 - 1'b1]: code_o = KEY_2;
      [EDGE_400 + 1'b1 : EDGE_600 - 1'b1]: code_o = KEY_3;
      [EDGE_300 + 1'b1 : EDGE_400 - 1'b1]: code_o = KEY_4;
      [EDGE_100 + 1'b1 : EDGE_300 - 1'b1]: code_o = KEY_5;
      [0 : EDGE_100 - 1'b1]:               code_o = KEY_6;
      default:                             code_o = KEY_NONE;
    endcase
  end

endmodule

@@ rtl/lkdr_core.sv @@
module lkdr_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lkdr_pkg::cfg_t                 cfg_i,
  input  logic                           fire_i,
  input  logic [lkdr_pkg::KEY_BITS-1:0]  code1_i,
  input  logic [lkdr_pkg::KEY_BITS-1:0]  code2_i,
  input  logic [lkdr_pkg::KEY_BITS-1:0]  code3_i,
  input  logic [lkdr_pkg::TIME_BITS-1:0] now_i,
  output logic [lkdr_pkg::KEY_BITS-1:0]  key_o
);
  import lkdr_pkg::*;

  logic [TIME_BITS-1:0]  last_q, last_d;
  logic [COUNT_BITS-1:0] count_q, count_d, count_base;
  logic [TIME_BITS-1:0]  diff;
  logic [DIFF_BITS-1:0]  diff_ext;
  logic [CFG_BITS-1:0]   delay;
  logic                  later, idle_el, press_el, hit, match;

  // time going backwards counts as not elapsed
  assign later    = now_i > last_q;
  assign diff     = now_i - last_q;
  assign diff_ext = DIFF_BITS'(diff);
  assign idle_el  = later && (diff_ext > DIFF_BITS'(cfg_i.idle_reset_time));

  assign delay = (!idle_el && (count_q > cfg_i.fast_after_count)) ?
                 cfg_i.fast_repeat_delay : cfg_i.slow_repeat_delay;
  assign press_el = later && (diff_ext > DIFF_BITS'(delay));

  assign count_base = idle_el ? '0 : count_q;
  assign hit        = (code1_i != KEY_NONE) && press_el;
  assign count_d    = (hit && (count_base != COUNT_MAX)) ? count_base + 1'b1 : count_base;
  assign match      = hit && (code1_i == code2_i) && (code2_i == code3_i);
  assign last_d     = match ? now_i : last_q;
  assign key_o      = match ? code3_i : KEY_NONE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      count_q <= '0;
    end else if (fire_i) begin
      last_q  <= last_d;
      count_q <= count_d;
    end
  end

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(last_q) && $stable(count_q))
    else $error("repeat state changed without a transaction");

  a_press_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (key_o != KEY_NONE) |=> last_q == $past(now_i))
    else $error("reported press did not record its time");

  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (count_q == COUNT_MAX) && !idle_el |=> count_q == COUNT_MAX)
    else $error("repeat count wrapped");

  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && idle_el |=> count_q <= COUNT_BITS'(1))
    else $error("idle gap did not clear the repeat count");

endmodule

@@ rtl/ladder_keypad_debounce_repeat.sv @@
// Resistor-ladder keypad decoder with debounce and key repeat. Each input
// transaction is one scan (three ADC samples and a microsecond timestamp) and
// yields exactly one key_code transaction, 1..6 for a reported key or 0 for none.
// A scan is accepted every cycle unless the result register is full and not
// being drained; it is taken into the input register and its result is offered
// from the result register. The repeat rate is set by the repeat state (last press
// time and repeat count), read and updated as a scan moves between those two
// registers. Configuration is written over APB at byte addresses 0, 4, 8, 12;
// the user must do so only while no scan is in flight; the block does not check.
module ladder_keypad_debounce_repeat (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lkdr_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [lkdr_pkg::DATA_BITS-1:0]   pwdata,
  output logic [lkdr_pkg::DATA_BITS-1:0]   prdata,
  output logic                             pready,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [lkdr_pkg::SAMPLE_BITS-1:0] first_sample_i,
  input  logic [lkdr_pkg::SAMPLE_BITS-1:0] second_sample_i,
  input  logic [lkdr_pkg::SAMPLE_BITS-1:0] third_sample_i,
  input  logic [lkdr_pkg::TIME_BITS-1:0]   now_us_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [lkdr_pkg::KEY_BITS-1:0]    key_code_o
);
  import lkdr_pkg::*;

  cfg_t                   cfg;
  logic                   s1_valid_q, out_valid_q;
  logic [SAMPLE_BITS-1:0] s1_first_q, s1_second_q, s1_third_q;
  logic [TIME_BITS-1:0]   s1_now_q;
  logic [KEY_BITS-1:0]    code1, code2, code3, key_d, key_q;
  logic                   advance, fire;

  lkdr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // result register free or being drained this cycle
  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = s1_valid_q && advance;
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_first_q  <= first_sample_i;
      s1_second_q <= second_sample_i;
      s1_third_q  <= third_sample_i;
      s1_now_q    <= now_us_i;
    end
  end

  lkdr_classify u_cls1 (.sample_i(s1_first_q),  .code_o(code1));
  lkdr_classify u_cls2 (.sample_i(s1_second_q), .code_o(code2));
  lkdr_classify u_cls3 (.sample_i(s1_third_q),  .code_o(code3));

  lkdr_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .fire_i  (fire),
    .code1_i (code1),
    .code2_i (code2),
    .code3_i (code3),
    .now_i   (s1_now_q),
    .key_o   (key_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      key_q <= key_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign key_code_o  = key_q;

endmodule

@@ dv/tb_ladder_keypad_debounce_repeat.sv @@
module tb_ladder_keypad_debounce_repeat;
  timeunit 1ns;
  timeprecision 1ps;

  import lkdr_pkg::*;

  // predicts key_code per scan and holds the keys still owed by the block
  class key_scoreboard;
    logic [CFG_BITS-1:0]   slow_delay;
    logic [CFG_BITS-1:0]   fast_delay;
    logic [CFG_BITS-1:0]   idle_time;
    logic [COUNT_BITS-1:0] fast_after;
    logic [TIME_BITS-1:0]  last_press;
    logic [COUNT_BITS-1:0] repeats;
    logic [KEY_BITS-1:0]   expected_keys[$];
    int unsigned           mismatches;

    function new();
      slow_delay = SLOW_DELAY_RST;
      fast_delay = FAST_DELAY_RST;
      idle_time  = IDLE_TIME_RST;
      fast_after = FAST_AFTER_RST;
      last_press = '0;
      repeats    = '0;
      mismatches = 0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [DATA_BITS-1:0] value);
      case (idx)
        REG_SLOW_DELAY: slow_delay = value[CFG_BITS-1:0];
        REG_FAST_DELAY: fast_delay = value[CFG_BITS-1:0];
        REG_IDLE_TIME:  idle_time  = value[CFG_BITS-1:0];
        REG_FAST_AFTER: fast_after = value[COUNT_BITS-1:0];
        default: ;
      endcase
    endfunction

    function logic [KEY_BITS-1:0] band(logic [SAMPLE_BITS-1:0] v);
      if (v > EDGE_900) return KEY_NONE;
      if (v < EDGE_900 && v > EDGE_700) return KEY_1;
      if (v < EDGE_700 && v > EDGE_600) return KEY_2;
      if (v < EDGE_600 && v > EDGE_400) return KEY_3;
      if (v < EDGE_400 && v > EDGE_300) return KEY_4;
      if (v < EDGE_300 && v > EDGE_100) return KEY_5;
      if (v < EDGE_100) return KEY_6;
      return KEY_NONE;
    endfunction

    // strictly more than gap since then; never true when time went backwards
    function bit gap_passed(logic [TIME_BITS-1:0] now, logic [TIME_BITS-1:0] then_t,
                            logic [CFG_BITS-1:0] gap);
      if (now <= then_t) return 1'b0;
      return (DIFF_BITS'(now - then_t) > DIFF_BITS'(gap));
    endfunction

    function void note_scan(logic [SAMPLE_BITS-1:0] s1, logic [SAMPLE_BITS-1:0] s2,
                            logic [SAMPLE_BITS-1:0] s3, logic [TIME_BITS-1:0] now);
      logic [KEY_BITS-1:0] c1, c2, c3, key;
      logic [CFG_BITS-1:0] delay;
      c1 = band(s1);
      c2 = band(s2);
      c3 = band(s3);
      key = KEY_NONE;
      delay = slow_delay;
      if (repeats > fast_after) delay = fast_delay;
      if (gap_passed(now, last_press, idle_time)) begin
        delay = slow_delay;
        repeats = '0;
      end
      if (c1 != KEY_NONE && gap_passed(now, last_press, delay)) begin
        if (repeats != COUNT_MAX) repeats = repeats + 1'b1;
        if (c1 == c2 && c2 == c3) begin
          key = c3;
          last_press = now;
        end
      end
      expected_keys.push_back(key);
    endfunction

    function void check_key(logic [KEY_BITS-1:0] actual);
      logic [KEY_BITS-1:0] want;
      if (expected_keys.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("key_code %0d arrived with no scan waiting", actual);
        return;
      end
      want = expected_keys.pop_front();
      if (actual !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("key_code wrong: expected %0d, got %0d", want, actual);
      end
    endfunction

    function int pending();
      return expected_keys.size();
    endfunction
  endclass

  localparam int IDLE_LIMIT = 2000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [ADDR_BITS-1:0]   paddr = '0;
  logic [DATA_BITS-1:0]   pwdata = '0;
  logic [DATA_BITS-1:0]   prdata;
  logic                   pready;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic [SAMPLE_BITS-1:0] first_sample_i = '0;
  logic [SAMPLE_BITS-1:0] second_sample_i = '0;
  logic [SAMPLE_BITS-1:0] third_sample_i = '0;
  logic [TIME_BITS-1:0]   now_us_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [KEY_BITS-1:0]    key_code_o;

  key_scoreboard   sb;
  longint unsigned scan_clock = 0;
  int              burst_left = 0;
  int              calm_left = 0;
  int              stall_left = 0;
  int              quiet_cycles = 0;

  ladder_keypad_debounce_repeat DUT (.*);

  always #1ns clk_i = ~clk_i;

  // receiver: calm stretches, short stalls, otherwise mostly ready
  always @(posedge clk_i) begin
    if (calm_left != 0) begin
      calm_left--;
      out_ready_i <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      case ($urandom_range(0, 9))
        0: calm_left = $urandom_range(10, 60);
        1, 2: stall_left = $urandom_range(1, 8);
        default: ;
      endcase
      out_ready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  // input and output transactions are both taken here so their order is fixed
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        sb.note_scan(first_sample_i, second_sample_i, third_sample_i, now_us_i);
      if (out_valid_o && out_ready_i)
        sb.check_key(key_code_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (psel && penable && pready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("ladder_keypad_debounce_repeat: mismatch");
        $finish;
      end
    end
  end

  task automatic scan(input logic [SAMPLE_BITS-1:0] s1, input logic [SAMPLE_BITS-1:0] s2,
                      input logic [SAMPLE_BITS-1:0] s3, input logic [TIME_BITS-1:0] now);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    in_valid_i      <= 1'b1;
    first_sample_i  <= s1;
    second_sample_i <= s2;
    third_sample_i  <= s3;
    now_us_i        <= now;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    burst_left--;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // leaves psel high so back-to-back writes never lower and raise it in one step
  task automatic apb_write(input reg_idx_e idx, input logic [DATA_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.write_reg(idx, value);
  endtask

  // upper pwdata bits are junk; the registers keep only their own width
  task automatic set_config(input int unsigned slow, input int unsigned fast,
                            input int unsigned idle, input int unsigned after);
    apb_write(REG_SLOW_DELAY, {8'($urandom_range(0, 255)), slow[CFG_BITS-1:0]});
    apb_write(REG_FAST_DELAY, {8'($urandom_range(0, 255)), fast[CFG_BITS-1:0]});
    apb_write(REG_IDLE_TIME,  {8'($urandom_range(0, 255)), idle[CFG_BITS-1:0]});
    apb_write(REG_FAST_AFTER, {28'($urandom()), after[COUNT_BITS-1:0]});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] in_band(int key);
    case (key)
      1: return SAMPLE_BITS'($urandom_range(701, 899));
      2: return SAMPLE_BITS'($urandom_range(601, 699));
      3: return SAMPLE_BITS'($urandom_range(401, 599));
      4: return SAMPLE_BITS'($urandom_range(301, 399));
      5: return SAMPLE_BITS'($urandom_range(101, 299));
      6: return SAMPLE_BITS'($urandom_range(0, 99));
      default: begin
        case ($urandom_range(0, 6))
          0: return EDGE_900;
          1: return EDGE_700;
          2: return EDGE_600;
          3: return EDGE_400;
          4: return EDGE_300;
          5: return EDGE_100;
          default: return SAMPLE_BITS'($urandom_range(901, 1023));
        endcase
      end
    endcase
  endfunction

  // time steps cluster around the programmed delays so every compare is hit on both sides
  function automatic longint unsigned time_step();
    longint unsigned base;
    longint unsigned step;
    case ($urandom_range(0, 4))
      0: base = sb.slow_delay;
      1: base = sb.fast_delay;
      2: base = sb.idle_time;
      3: base = $urandom_range(0, sb.slow_delay);
      default: base = 0;
    endcase
    step = base + $urandom_range(0, 2);
    step = (step == 0) ? 0 : step - 1;
    if (scan_clock + step > 64'hF000_0000) step = $urandom_range(0, 3);
    return step;
  endfunction

  task automatic key_traffic(input int n);
    int kind;
    int k;
    logic [SAMPLE_BITS-1:0] s1, s2, s3;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 99);
      k = $urandom_range(1, 6);
      if (kind < 72) begin
        scan_clock += time_step();
        scan(in_band(k), in_band(k), in_band(k), TIME_BITS'(scan_clock));
      end else if (kind < 84) begin
        // bounce: one of the later samples lands on another key or none
        scan_clock += time_step();
        s1 = in_band(k);
        s2 = in_band(k);
        s3 = in_band(k);
        if ($urandom_range(0, 1)) s2 = in_band((k % 6) + 1);
        else s3 = in_band($urandom_range(0, 1) ? 0 : (k % 6) + 1);
        scan(s1, s2, s3, TIME_BITS'(scan_clock));
      end else if (kind < 91) begin
        scan_clock += time_step();
        scan(in_band(0), in_band(k), in_band(k), TIME_BITS'(scan_clock));
      end else if (kind < 95) begin
        // time going backwards with a clean key
        scan(in_band(k), in_band(k), in_band(k),
             TIME_BITS'(scan_clock - ((scan_clock > 50) ? $urandom_range(1, 50) : scan_clock)));
      end else begin
        // random noise; third sample on no key so no press can be recorded
        scan(SAMPLE_BITS'($urandom_range(0, 1023)), SAMPLE_BITS'($urandom_range(0, 1023)),
             in_band(0), $urandom());
      end
    end
    drain();
  endtask

  task automatic random_small_config(input int unsigned after);
    int unsigned slow;
    slow = $urandom_range(2, 60);
    set_config(slow, $urandom_range(0, slow), $urandom_range(slow, 4 * slow), after);
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed scans with reset settings
    scan(10'd500, 10'd500, 10'd500, 32'd0);
    scan_clock = 1_000_000;
    scan(10'd1023, 10'd1023, 10'd1023, TIME_BITS'(scan_clock));
    scan_clock += 250_000;
    scan(EDGE_900, EDGE_900, EDGE_900, TIME_BITS'(scan_clock));
    scan_clock += 250_000;
    scan(EDGE_700, EDGE_700, EDGE_700, TIME_BITS'(scan_clock));
    scan_clock += 250_000;
    scan(EDGE_600, EDGE_600, EDGE_600, TIME_BITS'(scan_clock));
    scan_clock += 250_000;
    scan(EDGE_400, EDGE_400, EDGE_400, TIME_BITS'(scan_clock));
    scan_clock += 250_000;
    scan(EDGE_300, EDGE_300, EDGE_300, TIME_BITS'(scan_clock));
    scan_clock += 250_000;
    scan(EDGE_100, EDGE_100, EDGE_100, TIME_BITS'(scan_clock));
    scan_clock += 200_001;
    scan(10'd701, 10'd899, 10'd800, TIME_BITS'(scan_clock));
    scan_clock += 200_001;
    scan(10'd601, 10'd699, 10'd650, TIME_BITS'(scan_clock));
    scan_clock += 200_001;
    scan(10'd401, 10'd599, 10'd500, TIME_BITS'(scan_clock));
    scan_clock += 200_001;
    scan(10'd301, 10'd399, 10'd350, TIME_BITS'(scan_clock));
    scan_clock += 200_001;
    scan(10'd101, 10'd299, 10'd200, TIME_BITS'(scan_clock));
    scan_clock += 200_001;
    scan(10'd0, 10'd99, 10'd50, TIME_BITS'(scan_clock));
    // slow delay exactly met; the repeat count is past fast_after, so the fast delay applies
    scan_clock += 200_000;
    scan(10'd800, 10'd800, 10'd800, TIME_BITS'(scan_clock));
    // disagreeing samples inside the repeat delay report no key
    scan_clock += 1;
    scan(10'd800, 10'd650, 10'd800, TIME_BITS'(scan_clock));
    scan(10'd500, 10'd500, 10'd500, TIME_BITS'(scan_clock - 300_000));
    scan(10'd800, 10'd500, 10'd500, 32'hFFFF_FFFF);
    for (int i = 0; i < 8; i++) begin
      scan_clock += (i < 6) ? 200_001 : 80_001;
      scan(10'd350, 10'd350, 10'd350, TIME_BITS'(scan_clock));
    end
    scan_clock += 400_001;
    scan(10'd50, 10'd50, 10'd50, TIME_BITS'(scan_clock));
    drain();

    key_traffic(60);
    random_small_config($urandom_range(0, 15));
    key_traffic(70);
    set_config(0, 0, 0, 0);
    key_traffic(40);
    set_config(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 15);
    key_traffic(30);
    random_small_config(0);
    key_traffic(70);
    random_small_config($urandom_range(0, 8));
    key_traffic(80);
    set_config(200_000, 80_000, 400_000, 5);
    key_traffic(30);

    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ladder_keypad_debounce_repeat: match");
    end else begin
      $display("ladder_keypad_debounce_repeat: mismatch");
    end
    $finish;
  end

endmodule
